### rtl/gfa_pkg.sv
// Shared types, codes and field arithmetic for the GF(2^8) arithmetic unit.
package gfa_pkg;

  localparam logic [7:0] GF_REDUCE  = 8'h1b;
  localparam logic [7:0] GF_INV_EXP = 8'd254;
  localparam logic [7:0] GF_ONE     = 8'h01;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_POW = 3'd2,
    OP_INV = 3'd3,
    OP_DIV = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ACC_ONE,
    ACC_ZERO,
    ACC_XOR,
    ACC_MUL
  } acc_sel_t;

  typedef enum logic [1:0] {
    MS_AB,
    MS_SQ,
    MS_BASE,
    MS_HOLD
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     base_sel_b;
    logic     exp_inv;
    logic     flag_val;
    logic     acc_we;
    acc_sel_t acc_sel;
    mul_sel_t mul_sel;
    logic [2:0] bit_idx;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_bit;
    logic a_zero;
    logic b_zero;
    logic out_free;
  } status_t;

  // Shift-and-add product reduced by x^8+x^4+x^3+x+1
  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] xs;
    acc = '0;
    xs  = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) acc = acc ^ xs;
      xs = xs[7] ? ({xs[6:0], 1'b0} ^ GF_REDUCE) : {xs[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

### rtl/gfa_ctrl.sv
// Sequencer for square-and-multiply: walks the exponent bits from the top.
module gfa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        op,
  input  gfa_pkg::status_t  sts,
  output gfa_pkg::cmd_t     cmd,
  output gfa_pkg::state_t   state
);

  gfa_pkg::state_t state_next;
  logic [2:0]      cnt;
  logic [2:0]      cnt_next;
  logic            is_div;
  logic            is_div_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gfa_pkg::ST_IDLE;
      cnt    <= '0;
      is_div <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      is_div <= is_div_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    is_div_next = is_div;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.acc_sel = gfa_pkg::ACC_ZERO;
    cmd.mul_sel = gfa_pkg::MS_AB;
    cmd.bit_idx = cnt;
    unique case (state)
      gfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.acc_we  = 1'b1;
          cnt_next    = 3'd7;
          is_div_next = (op == gfa_pkg::OP_DIV);
          state_next  = gfa_pkg::ST_DONE;
          unique case (op)
            gfa_pkg::OP_ADD: cmd.acc_sel = gfa_pkg::ACC_XOR;
            gfa_pkg::OP_MUL: cmd.acc_sel = gfa_pkg::ACC_MUL;
            gfa_pkg::OP_POW: begin
              cmd.acc_sel = gfa_pkg::ACC_ONE;
              state_next  = gfa_pkg::ST_SQR;
            end
            gfa_pkg::OP_INV: begin
              cmd.exp_inv = 1'b1;
              if (sts.a_zero) begin
                cmd.flag_val = 1'b1;
              end else begin
                cmd.acc_sel = gfa_pkg::ACC_ONE;
                state_next  = gfa_pkg::ST_SQR;
              end
            end
            gfa_pkg::OP_DIV: begin
              cmd.exp_inv    = 1'b1;
              cmd.base_sel_b = 1'b1;
              if (sts.b_zero) begin
                cmd.flag_val = 1'b1;
              end else begin
                cmd.acc_sel = gfa_pkg::ACC_ONE;
                state_next  = gfa_pkg::ST_SQR;
              end
            end
            default: cmd.acc_sel = gfa_pkg::ACC_ZERO;
          endcase
        end
      end
      gfa_pkg::ST_SQR: begin
        cmd.acc_we  = 1'b1;
        cmd.acc_sel = gfa_pkg::ACC_MUL;
        cmd.mul_sel = gfa_pkg::MS_SQ;
        if (sts.exp_bit) begin
          state_next = gfa_pkg::ST_MUL;
        end else if (cnt == 3'd0) begin
          state_next = is_div ? gfa_pkg::ST_FIN : gfa_pkg::ST_DONE;
        end else begin
          cnt_next = cnt - 3'd1;
        end
      end
      gfa_pkg::ST_MUL: begin
        cmd.acc_we  = 1'b1;
        cmd.acc_sel = gfa_pkg::ACC_MUL;
        cmd.mul_sel = gfa_pkg::MS_BASE;
        if (cnt == 3'd0) begin
          state_next = is_div ? gfa_pkg::ST_FIN : gfa_pkg::ST_DONE;
        end else begin
          cnt_next   = cnt - 3'd1;
          state_next = gfa_pkg::ST_SQR;
        end
      end
      gfa_pkg::ST_FIN: begin
        // multiply the inverse of b by a
        cmd.acc_we  = 1'b1;
        cmd.acc_sel = gfa_pkg::ACC_MUL;
        cmd.mul_sel = gfa_pkg::MS_HOLD;
        state_next  = gfa_pkg::ST_DONE;
      end
      gfa_pkg::ST_DONE: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = gfa_pkg::ST_IDLE;
        end
      end
      default: state_next = gfa_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/gfa_dp.sv
// Datapath: operand registers, shared field multiplier and output register.
module gfa_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       a,
  input  logic [7:0]       b,
  input  logic [7:0]       exponent,
  input  gfa_pkg::cmd_t    cmd,
  output gfa_pkg::status_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       result,
  output logic             zero_divisor
);

  logic [7:0] acc;
  logic [7:0] base;
  logic [7:0] exp_reg;
  logic [7:0] a_hold;
  logic       flag;
  logic [7:0] mul_x;
  logic [7:0] mul_y;
  logic [7:0] prod;
  logic [7:0] acc_next;

  always_comb begin
    unique case (cmd.mul_sel)
      gfa_pkg::MS_AB:   begin mul_x = a;   mul_y = b;      end
      gfa_pkg::MS_SQ:   begin mul_x = acc; mul_y = acc;    end
      gfa_pkg::MS_BASE: begin mul_x = acc; mul_y = base;   end
      gfa_pkg::MS_HOLD: begin mul_x = acc; mul_y = a_hold; end
      default:          begin mul_x = acc; mul_y = acc;    end
    endcase
    prod = gfa_pkg::gf_mul(mul_x, mul_y);
    unique case (cmd.acc_sel)
      gfa_pkg::ACC_ONE:  acc_next = gfa_pkg::GF_ONE;
      gfa_pkg::ACC_ZERO: acc_next = '0;
      gfa_pkg::ACC_XOR:  acc_next = a ^ b;
      gfa_pkg::ACC_MUL:  acc_next = prod;
      default:           acc_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_we) acc <= acc_next;
    if (cmd.load) begin
      base    <= cmd.base_sel_b ? b : a;
      exp_reg <= cmd.exp_inv ? gfa_pkg::GF_INV_EXP : exponent;
      a_hold  <= a;
      flag    <= cmd.flag_val;
    end
    if (cmd.out_load) begin
      result       <= acc;
      zero_divisor <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.exp_bit  = exp_reg[cmd.bit_idx];
  assign sts.a_zero   = (a == 8'd0);
  assign sts.b_zero   = (b == 8'd0);
  assign sts.out_free = !out_valid || out_ready;

endmodule

### rtl/gf256_arithmetic_unit.sv
// Top level of the GF(2^8) arithmetic unit: controller plus datapath.
// Arithmetic over GF(2^8) with the polynomial x^8+x^4+x^3+x+1. Each transfer on the
// input selects add, multiply, power, inverse or divide and yields exactly one result
// transfer. Add, multiply, unused codes and a zero divisor go from the accept state to
// the output-load state. Power, inverse and divide run square-and-multiply over the
// eight exponent bits on one shared multiplier, one multiply per cycle: after the accept
// state, one squaring per exponent bit and one extra multiply per set exponent bit (plus
// the final multiply by a for divide), then the output load. One item is in work at a
// time; the output register lets a new item enter while a result waits.
// zero_divisor is raised, with result 0, for the inverse of zero and division by zero.
module gf256_arithmetic_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] exponent,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] result,
  output logic       zero_divisor
);

  gfa_pkg::cmd_t    cmd;
  gfa_pkg::status_t sts;
  gfa_pkg::state_t  state;

  gfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  gfa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .a            (a),
    .b            (b),
    .exponent     (exponent),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result),
    .zero_divisor (zero_divisor)
  );

  // an accepted item keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // a raised error flag always comes with a zero result
  a_flag_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_divisor) |-> (result == 8'd0))
    else $error("zero_divisor set with non-zero result");

  // output register is only loaded from the final state
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == gfa_pkg::ST_DONE))
    else $error("output loaded outside the final state");

endmodule
